/* src/hvn_pkg.sv */
// Shared types, constants and codes of the heightmap vertex normal block.
package hvn_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int GW_W       = 11;
    localparam int GH_W       = 13;
    localparam int CFG_W      = 13;

    localparam int SUM_W = 18;   // sum of up to four Q1.15 values
    localparam int MAG_W = 17;
    localparam int SQ_W  = 35;
    localparam int SS_W  = 36;
    localparam int QUO_W = 33;
    localparam int RT_W  = 34;
    localparam int CNT_W = 6;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = (QUO_W + 1) / 2;

    localparam int FACE_UP = 10;
    localparam logic [14:0] Q15_MAX = 15'h7FFF;

    localparam logic [1:0] REG_GRID_WIDTH     = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_HEIGHT_CHANNEL = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef sum_t [2:0] vec_t;
    typedef logic signed [15:0] q15_t;
    typedef q15_t [2:0] nrm_t;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic [COL_W-1:0] vertex_col;
        logic [ROW_W-1:0] vertex_row;
        q15_t             normal_x;
        q15_t             normal_y;
        q15_t             normal_z;
        logic             last_of_run;
    } result_t;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SQ,
        N_DIV,
        N_SQRT,
        N_DONE
    } norm_state_t;

    typedef enum logic [3:0] {
        C_IDLE,
        C_RD0,
        C_RD1,
        C_RD2,
        C_FACE,
        C_FACE_WAIT,
        C_SUM1,
        C_SUM1_WAIT,
        C_EMIT1,
        C_SUM2,
        C_SUM2_WAIT,
        C_EMIT2,
        C_UPDATE
    } ctl_state_t;

    typedef enum logic [1:0] {
        SEL_FACE,
        SEL_SUM1,
        SEL_SUM2
    } norm_sel_t;

    typedef struct packed {
        logic      accept;
        logic      rd_a;
        logic      cap_a;
        logic      rd_b;
        logic      cap_b;
        logic      norm_start;
        norm_sel_t norm_sel;
        logic      cap_cur;
        logic      load_out;
        logic      out_last;
        logic      update;
    } ctl_cmd_t;

    typedef struct packed {
        logic row0;
        logic has_right;
        logic last_row;
        logic norm_done;
        logic out_busy;
    } ctl_status_t;

endpackage

/* src/hvn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/hvn_norm.sv */
// Iterative vector normalizer: one quotient bit or one root bit per cycle.
module hvn_norm import hvn_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  vec_t vec,
    output logic done,
    output nrm_t nrm
);

    norm_state_t state_reg, state_next;
    vec_t                   vin_reg, vin_next;
    logic [2:0][SQ_W-1:0]   sq_reg, sq_next;
    logic [SS_W-1:0]        ss_reg, ss_next;
    logic [1:0]             comp_reg, comp_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [SS_W-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [QUO_W-1:0]       bit_reg, bit_next;
    logic [RT_W-1:0]        root_reg, root_next;
    nrm_t                   nrm_reg, nrm_next;

    sum_t             cur;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  prod;
    logic [SS_W:0]    shifted;
    logic             ge;
    logic [RT_W-1:0]  trial;
    logic [RT_W-1:0]  root_new;
    logic [17:0]      rnd;
    logic [14:0]      mag15;
    q15_t             comp_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vin_reg  <= vin_next;
        sq_reg   <= sq_next;
        ss_reg   <= ss_next;
        comp_reg <= comp_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
        nrm_reg  <= nrm_next;
    end

    always_comb
    begin
        state_next = state_reg;
        vin_next   = vin_reg;
        sq_next    = sq_reg;
        ss_next    = ss_reg;
        comp_next  = comp_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        root_next  = root_reg;
        nrm_next   = nrm_reg;
        done       = 1'b0;

        cur  = $signed(vin_reg[(state_reg == N_SQ) ? cnt_reg[1:0] : comp_reg]);
        mag  = (cur < 0) ? MAG_W'(-cur) : MAG_W'(cur);
        prod = SQ_W'(mag * mag);

        shifted = (cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge      = (shifted >= {1'b0, ss_reg});

        trial    = root_reg + RT_W'(bit_reg);
        root_new = ({1'b0, quo_reg} >= trial) ? ((root_reg >> 1) + RT_W'(bit_reg))
                                              : (root_reg >> 1);
        // round the doubled root, then saturate
        rnd   = {1'b0, root_new[16:0]} + 18'd1;
        mag15 = (rnd[17:1] > {2'b00, Q15_MAX}) ? Q15_MAX : rnd[15:1];
        comp_val = (cur < 0) ? -$signed({1'b0, mag15}) : $signed({1'b0, mag15});

        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    vin_next   = vec;
                    ss_next    = '0;
                    cnt_next   = '0;
                    state_next = N_SQ;
                end
            end
            N_SQ:
            begin
                sq_next[cnt_reg[1:0]] = prod;
                ss_next  = ss_reg + SS_W'(prod);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(2))
                begin
                    comp_next = '0;
                    cnt_next  = '0;
                    rem_next  = SS_W'(sq_next[0]);
                    quo_next  = '0;
                    if (ss_next == '0)
                    begin
                        nrm_next   = '0;
                        state_next = N_DONE;
                    end
                    else
                    begin
                        state_next = N_DIV;
                    end
                end
            end
            N_DIV:
            begin
                rem_next = ge ? SS_W'(shifted - {1'b0, ss_reg}) : SS_W'(shifted);
                quo_next = {quo_reg[QUO_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    root_next  = '0;
                    bit_next   = QUO_W'(1) << (QUO_W - 1);
                    state_next = N_SQRT;
                end
            end
            N_SQRT:
            begin
                if ({1'b0, quo_reg} >= trial)
                begin
                    quo_next = QUO_W'({1'b0, quo_reg} - trial);
                end
                root_next = root_new;
                bit_next  = bit_reg >> 2;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    nrm_next[comp_reg] = comp_val;
                    cnt_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        state_next = N_DONE;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 1'b1;
                        rem_next   = SS_W'(sq_reg[comp_reg + 1'b1]);
                        quo_next   = '0;
                        state_next = N_DIV;
                    end
                end
            end
            N_DONE:
            begin
                done       = 1'b1;
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    assign nrm = nrm_reg;

endmodule

/* src/hvn_ctrl.sv */
// Per-pixel sequencer: reads, face normal (not in the first row or last column), up to two vertex results, update.
module hvn_ctrl import hvn_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  ctl_status_t status,
    output ctl_cmd_t    cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.norm_sel = SEL_FACE;
        pixel_ready  = 1'b0;

        case (state_reg)
            C_IDLE:
            begin
                pixel_ready = 1'b1;
                if (pixel_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = C_RD0;
                end
            end
            C_RD0:
            begin
                cmd.rd_a   = 1'b1;
                state_next = C_RD1;
            end
            C_RD1:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = C_RD2;
            end
            C_RD2:
            begin
                cmd.cap_b = 1'b1;
                if (status.row0)
                begin
                    state_next = C_UPDATE;
                end
                else if (status.has_right)
                begin
                    state_next = C_FACE;
                end
                else
                begin
                    state_next = C_SUM1;
                end
            end
            C_FACE:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_sel   = SEL_FACE;
                state_next     = C_FACE_WAIT;
            end
            C_FACE_WAIT:
            begin
                if (status.norm_done)
                begin
                    cmd.cap_cur = 1'b1;
                    state_next  = C_SUM1;
                end
            end
            C_SUM1:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_sel   = SEL_SUM1;
                state_next     = C_SUM1_WAIT;
            end
            C_SUM1_WAIT:
            begin
                if (status.norm_done)
                begin
                    state_next = C_EMIT1;
                end
            end
            C_EMIT1:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = !status.last_row;
                    state_next   = status.last_row ? C_SUM2 : C_UPDATE;
                end
            end
            C_SUM2:
            begin
                cmd.norm_start = 1'b1;
                cmd.norm_sel   = SEL_SUM2;
                state_next     = C_SUM2_WAIT;
            end
            C_SUM2_WAIT:
            begin
                if (status.norm_done)
                begin
                    state_next = C_EMIT2;
                end
            end
            C_EMIT2:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = C_UPDATE;
                end
            end
            C_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

endmodule

/* src/hvn_dp.sv */
// Datapath: configuration, counters, line stores, normalizer and result register.
module hvn_dp import hvn_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_cmd_t         cmd,
    output ctl_status_t      status,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [GW_W-1:0]  gw_reg;
    logic [GH_W-1:0]  gh_reg;
    logic [1:0]       ch_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [7:0]       hv_reg, base_reg, right_reg;
    nrm_t             up_reg, left_reg, ul_reg, cur_reg;
    logic             out_valid_reg;
    result_t          out_reg;

    logic [GW_W-1:0]  w_eff;
    logic [GH_W-1:0]  h_eff;
    logic [GW_W-1:0]  col_inc;
    logic [GH_W-1:0]  row_inc;
    logic             has_left, has_up, has_right, last_row, row0;
    logic [7:0]       hv_sel;
    logic [7:0]       h_rdata;
    nrm_t             f_rdata;
    logic [COL_W-1:0] h_raddr;
    vec_t             face_vec, sum1, sum2, norm_in;
    logic             norm_done;
    nrm_t             norm_out;

    assign w_eff = (gw_reg < GW_W'(2)) ? GW_W'(2)
                 : (gw_reg > GW_W'(MAX_WIDTH)) ? GW_W'(MAX_WIDTH) : gw_reg;
    assign h_eff = (gh_reg < GH_W'(2)) ? GH_W'(2)
                 : (gh_reg > GH_W'(MAX_HEIGHT)) ? GH_W'(MAX_HEIGHT) : gh_reg;

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign has_right = (col_inc < w_eff);
    assign has_left  = (col_reg != '0);
    assign has_up    = (row_reg >= ROW_W'(2));
    assign row0      = (row_reg == '0);
    assign last_row  = (row_inc == h_eff);

    always_comb
    begin
        case (ch_reg)
            CH_RED:   hv_sel = pixel.pixel_red;
            CH_GREEN: hv_sel = pixel.pixel_green;
            default:  hv_sel = pixel.pixel_blue;
        endcase
    end

    assign h_raddr = cmd.rd_b ? col_inc[COL_W-1:0] : col_reg;

    hvn_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_height_line (
        .clk   (clk),
        .we    (cmd.update),
        .waddr (col_reg),
        .wdata (hv_reg),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    hvn_ram #(.WIDTH($bits(nrm_t)), .DEPTH(MAX_WIDTH)) u_face_line (
        .clk   (clk),
        .we    (cmd.update && !row0 && has_right),
        .waddr (col_reg),
        .wdata (cur_reg),
        .raddr (col_reg),
        .rdata (f_rdata)
    );

    // face vector is (h(x) - h(x+1), 10, h(x) - h(x,y+1))
    assign face_vec[0] = $signed({10'd0, base_reg}) - $signed({10'd0, right_reg});
    assign face_vec[1] = sum_t'(FACE_UP);
    assign face_vec[2] = $signed({10'd0, base_reg}) - $signed({10'd0, hv_reg});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum1[i] = (has_right ? sum_t'($signed(cur_reg[i])) : sum_t'(0))
                    + (has_left ? sum_t'($signed(left_reg[i])) : sum_t'(0))
                    + ((has_up && has_right) ? sum_t'($signed(up_reg[i])) : sum_t'(0))
                    + ((has_up && has_left) ? sum_t'($signed(ul_reg[i])) : sum_t'(0));
            sum2[i] = (has_right ? sum_t'($signed(cur_reg[i])) : sum_t'(0))
                    + (has_left ? sum_t'($signed(left_reg[i])) : sum_t'(0));
        end
        case (cmd.norm_sel)
            SEL_FACE: norm_in = face_vec;
            SEL_SUM1: norm_in = sum1;
            default:  norm_in = sum2;
        endcase
    end

    hvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.norm_start),
        .vec   (norm_in),
        .done  (norm_done),
        .nrm   (norm_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg        <= GW_W'(2);
            gh_reg        <= GH_W'(2);
            ch_reg        <= CH_RED;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.update)
            begin
                if (!row0)
                begin
                    ul_reg <= up_reg;
                    if (has_right)
                    begin
                        left_reg <= cur_reg;
                    end
                end
                // advance raster position, wrap at frame end
                if (has_right)
                begin
                    col_reg <= col_inc[COL_W-1:0];
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_inc[ROW_W-1:0];
                end
            end

            if (cfg_write)
            begin
                case (cfg_index)
                    REG_GRID_WIDTH:
                    begin
                        gw_reg  <= cfg_data[GW_W-1:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    REG_GRID_HEIGHT:
                    begin
                        gh_reg  <= cfg_data[GH_W-1:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    REG_HEIGHT_CHANNEL:
                    begin
                        ch_reg  <= cfg_data[1:0];
                        col_reg <= '0;
                        row_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hv_reg <= hv_sel;
        end
        if (cmd.cap_a)
        begin
            base_reg <= h_rdata;
            up_reg   <= f_rdata;
        end
        if (cmd.cap_b)
        begin
            right_reg <= h_rdata;
        end
        if (cmd.cap_cur)
        begin
            cur_reg <= norm_out;
        end
        if (cmd.load_out)
        begin
            out_reg.vertex_col  <= col_reg;
            out_reg.vertex_row  <= cmd.out_last && last_row ? row_reg : row_reg - 1'b1;
            out_reg.normal_x    <= norm_out[0];
            out_reg.normal_y    <= norm_out[1];
            out_reg.normal_z    <= norm_out[2];
            out_reg.last_of_run <= cmd.out_last;
        end
    end

    assign status.row0      = row0;
    assign status.has_right = has_right;
    assign status.last_row  = last_row;
    assign status.norm_done = norm_done;
    assign status.out_busy  = out_valid_reg && !result_ready;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* src/heightmap_vertex_normals.sv */
// Top level of the heightmap vertex normal generator.
// Pixels arrive in raster order; the selected channel is the height. Vertex (x,y) comes
// out when pixel (x,y+1) is taken, and a last-row pixel also gives vertex (x,H-1).
// One pixel at a time. Every vector goes through the one shared normalizer, which works
// out one quotient bit, then one root bit per cycle, per component. A finished word
// waits in the result register while the next pixel is taken. Write the geometry and
// channel registers only while idle; a write to any of them restarts the frame.
module heightmap_vertex_normals import hvn_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_ready,
    input  pixel_t           pixel,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctl_cmd_t    cmd;
    ctl_status_t status;

    hvn_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .status      (status),
        .cmd         (cmd)
    );

    hvn_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

endmodule

/* src/hvn_checker.sv */
// Port-level checks of the vertex normal block, bound to the top level.
module hvn_checker import hvn_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    pixel_valid,
    input logic    pixel_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // hold a stalled word
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // one pixel at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_ready |=> !pixel_ready)
        else $error("pixel taken while previous pixel in work");

    a_new_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !pixel_ready)
        else $error("new result while input side idle");

    // components saturate, and the up component is always positive
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.normal_x != 16'sh8000 && result.normal_z != 16'sh8000
                         && result.normal_y > 16'sh0000)
        else $error("normal component out of range");

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
